### hw/rtl/kufea_pkg.sv
// ----------------------------------------------------------------------------
// kufea_pkg
// shared constants, types and controller states for the edge acceptor
// ----------------------------------------------------------------------------
`default_nettype none

package kufea_pkg;

  localparam int NODES     = 1024;
  localparam int MAX_EDGES = 65536;
  localparam int NODE_W    = $clog2(NODES);
  localparam int CNT_W     = NODE_W + 1;
  localparam int EDGE_W    = $clog2(MAX_EDGES);
  localparam int WEIGHT_W  = 32;
  localparam int COST_W    = 32;
  localparam int SUM_W     = 42;

  localparam logic [CNT_W-1:0]  NODE_COUNT_RESET = CNT_W'(1024);
  localparam logic [CNT_W-1:0]  NODE_LIMIT       = CNT_W'(NODES);
  localparam logic [COST_W-1:0] COST_INIT        = COST_W'(2100000000);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_COMP,
    ST_LINK,
    ST_DONE
  } ctrl_state_t;

  // finished edge handed from the controller to the accumulator
  typedef struct packed {
    logic                done;
    logic                merge;
    logic [WEIGHT_W-1:0] weight;
    logic [COST_W-1:0]   cost;
    logic [EDGE_W-1:0]   number;
  } link_t;

endpackage

`default_nettype wire

### hw/rtl/kruskal_union_find_edge_acceptor.sv
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_acceptor
// union-find edge acceptor for sorted-edge minimum spanning tree building
// ----------------------------------------------------------------------------
// flow: an accepted edge walks endpoint_a to its root and compresses the path,
//   then endpoint_b likewise, then links the roots; each parent hop is walked
//   once and compressed once, paced by the registered parent memory read; an
//   out-of-range edge skips all that; one item at a time until its result is out
// reset: synchronous; a clearing pass then writes the identity into all
//   1024 parent entries, during which no item is accepted
// ----------------------------------------------------------------------------
`default_nettype none

module kruskal_union_find_edge_acceptor (
  input  wire logic          clk,
  input  wire logic          rst,
  // input edges
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // endpoint_a[9:0], endpoint_b[19:10], edge_weight[51:20],
  // edge_cost[83:52], edge_number[99:84], zero fill [103:100]
  input  wire logic [103:0]  s_axis_tdata,
  // results
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // total_weight[41:0], min_cost[73:42], min_cost_edge[89:74], zero fill [95:90]
  output logic      [95:0]   m_axis_tdata,
  // accepted[0]
  output logic      [0:0]    m_axis_tuser,
  // node_count register write
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [10:0]   cfg_data
);

  localparam int NW = kufea_pkg::NODE_W;
  localparam int WW = kufea_pkg::WEIGHT_W;
  localparam int CW = kufea_pkg::COST_W;
  localparam int EW = kufea_pkg::EDGE_W;
  localparam int SW = kufea_pkg::SUM_W;

  // parent memory ports
  logic          wr_en;
  logic [NW-1:0] wr_addr;
  logic [NW-1:0] wr_data;
  logic [NW-1:0] rd_addr;
  logic [NW-1:0] rd_data;

  kufea_pkg::link_t link;
  logic             out_free;

  logic          out_accepted;
  logic [SW-1:0] out_total;
  logic [CW-1:0] out_min_cost;
  logic [EW-1:0] out_min_edge;

  // the register is always writable
  assign cfg_ready = 1'b1;

  kufea_parent_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // find walks, compression and the link write all share the one memory
  kufea_find_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_endpoint_a (s_axis_tdata[NW-1:0]),
    .in_endpoint_b (s_axis_tdata[2*NW-1:NW]),
    .in_weight     (s_axis_tdata[2*NW+WW-1:2*NW]),
    .in_cost       (s_axis_tdata[2*NW+WW+CW-1:2*NW+WW]),
    .in_number     (s_axis_tdata[2*NW+WW+CW+EW-1:2*NW+WW+CW]),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .link          (link),
    .out_free      (out_free)
  );

  // running totals and the output register
  kufea_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .link         (link),
    .out_free     (out_free),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_accepted (out_accepted),
    .out_total    (out_total),
    .out_min_cost (out_min_cost),
    .out_min_edge (out_min_edge)
  );

  assign m_axis_tdata = {6'd0, out_min_edge, out_min_cost, out_total};
  assign m_axis_tuser = out_accepted;

endmodule

`default_nettype wire

### hw/rtl/kufea_parent_ram.sv
// ----------------------------------------------------------------------------
// kufea_parent_ram
// parent pointer memory, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module kufea_parent_ram (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [kufea_pkg::NODE_W-1:0]  wr_addr,
  input  wire logic [kufea_pkg::NODE_W-1:0]  wr_data,
  input  wire logic [kufea_pkg::NODE_W-1:0]  rd_addr,
  output logic      [kufea_pkg::NODE_W-1:0]  rd_data
);

  logic [kufea_pkg::NODE_W-1:0] mem [kufea_pkg::NODES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // write-first forwarding when both ports hit the same entry
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/kufea_find_ctrl.sv
// ----------------------------------------------------------------------------
// kufea_find_ctrl
// clearing pass, root walk, path compression and root linking
// ----------------------------------------------------------------------------
`default_nettype none

module kufea_find_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [kufea_pkg::NODE_W-1:0]    in_endpoint_a,
  input  wire logic [kufea_pkg::NODE_W-1:0]    in_endpoint_b,
  input  wire logic [kufea_pkg::WEIGHT_W-1:0]  in_weight,
  input  wire logic [kufea_pkg::COST_W-1:0]    in_cost,
  input  wire logic [kufea_pkg::EDGE_W-1:0]    in_number,
  input  wire logic                            cfg_valid,
  input  wire logic [kufea_pkg::CNT_W-1:0]     cfg_data,
  output logic                                 wr_en,
  output logic      [kufea_pkg::NODE_W-1:0]    wr_addr,
  output logic      [kufea_pkg::NODE_W-1:0]    wr_data,
  output logic      [kufea_pkg::NODE_W-1:0]    rd_addr,
  input  wire logic [kufea_pkg::NODE_W-1:0]    rd_data,
  output kufea_pkg::link_t                     link,
  input  wire logic                            out_free
);

  kufea_pkg::ctrl_state_t state, state_next;

  logic [kufea_pkg::NODE_W-1:0]   clr_cnt;
  logic [kufea_pkg::CNT_W-1:0]    node_count;
  logic [kufea_pkg::NODE_W-1:0]   eb_r;
  logic [kufea_pkg::WEIGHT_W-1:0] weight_r;
  logic [kufea_pkg::COST_W-1:0]   cost_r;
  logic [kufea_pkg::EDGE_W-1:0]   number_r;
  logic [kufea_pkg::NODE_W-1:0]   cur;
  logic [kufea_pkg::NODE_W-1:0]   start;
  logic [kufea_pkg::NODE_W-1:0]   p;
  logic [kufea_pkg::NODE_W-1:0]   root;
  logic [kufea_pkg::NODE_W-1:0]   ra;
  logic                           side;
  logic                           merge;

  logic [kufea_pkg::CNT_W-1:0] limit;
  logic                        in_fire;
  logic                        in_range;
  logic                        at_root;
  logic                        comp_end;

  assign limit    = (node_count > kufea_pkg::NODE_LIMIT) ? kufea_pkg::NODE_LIMIT : node_count;
  assign in_fire  = in_valid && in_ready;
  assign in_range = ({1'b0, in_endpoint_a} < limit) && ({1'b0, in_endpoint_b} < limit);
  assign at_root  = (rd_data == cur);
  assign comp_end = (rd_data == root);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= kufea_pkg::NODE_COUNT_RESET;
    end else if (cfg_valid) begin
      node_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= kufea_pkg::ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == kufea_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      kufea_pkg::ST_IDLE: begin
        if (in_fire) begin
          eb_r     <= in_endpoint_b;
          weight_r <= in_weight;
          cost_r   <= in_cost;
          number_r <= in_number;
          cur      <= in_endpoint_a;
          start    <= in_endpoint_a;
          side     <= 1'b0;
          merge    <= 1'b0;
        end
      end
      kufea_pkg::ST_FIND: begin
        if (at_root) begin
          root <= cur;
          if (start == cur) begin
            if (!side) begin
              ra    <= cur;
              side  <= 1'b1;
              start <= eb_r;
              cur   <= eb_r;
            end
          end else begin
            p <= start;
          end
        end else begin
          cur <= rd_data;
        end
      end
      kufea_pkg::ST_COMP: begin
        if (comp_end) begin
          if (!side) begin
            ra    <= root;
            side  <= 1'b1;
            start <= eb_r;
            cur   <= eb_r;
          end
        end else begin
          p <= rd_data;
        end
      end
      kufea_pkg::ST_LINK: begin
        merge <= (ra != root);
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      kufea_pkg::ST_CLEAR: begin
        if (clr_cnt == kufea_pkg::NODE_W'(kufea_pkg::NODES - 1)) begin
          state_next = kufea_pkg::ST_IDLE;
        end
      end
      kufea_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = in_range ? kufea_pkg::ST_FIND : kufea_pkg::ST_DONE;
        end
      end
      kufea_pkg::ST_FIND: begin
        if (at_root) begin
          if (start == cur) begin
            state_next = side ? kufea_pkg::ST_LINK : kufea_pkg::ST_FIND;
          end else begin
            state_next = kufea_pkg::ST_COMP;
          end
        end
      end
      kufea_pkg::ST_COMP: begin
        if (comp_end) begin
          state_next = side ? kufea_pkg::ST_LINK : kufea_pkg::ST_FIND;
        end
      end
      kufea_pkg::ST_LINK: begin
        state_next = kufea_pkg::ST_DONE;
      end
      kufea_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = kufea_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kufea_pkg::ST_IDLE;
      end
    endcase
  end

  // memory ports and handshake
  always_comb begin
    in_ready = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = p;
    wr_data  = root;
    rd_addr  = cur;
    case (state)
      kufea_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = clr_cnt;
      end
      kufea_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = in_endpoint_a;
      end
      kufea_pkg::ST_FIND: begin
        if (at_root) begin
          rd_addr = (start == cur) ? eb_r : start;
        end else begin
          rd_addr = rd_data;
        end
      end
      kufea_pkg::ST_COMP: begin
        wr_en   = 1'b1;
        rd_addr = comp_end ? eb_r : rd_data;
      end
      kufea_pkg::ST_LINK: begin
        wr_en   = (ra != root);
        wr_addr = ra;
      end
      default: begin
      end
    endcase
  end

  assign link.done   = (state == kufea_pkg::ST_DONE) && out_free;
  assign link.merge  = merge;
  assign link.weight = weight_r;
  assign link.cost   = cost_r;
  assign link.number = number_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("controller took a second item while busy");

  a_comp_not_root: assert property (@(posedge clk) disable iff (rst)
    (state == kufea_pkg::ST_COMP) |-> (p != root))
    else $error("compression walked onto the root");

  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    (state != kufea_pkg::ST_CLEAR) |=> (state != kufea_pkg::ST_CLEAR))
    else $error("clearing pass restarted without reset");

endmodule

`default_nettype wire

### hw/rtl/kufea_accum.sv
// ----------------------------------------------------------------------------
// kufea_accum
// weight total, best cost tracking and result output register
// ----------------------------------------------------------------------------
`default_nettype none

module kufea_accum (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  kufea_pkg::link_t                   link,
  output logic                               out_free,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_accepted,
  output logic      [kufea_pkg::SUM_W-1:0]   out_total,
  output logic      [kufea_pkg::COST_W-1:0]  out_min_cost,
  output logic      [kufea_pkg::EDGE_W-1:0]  out_min_edge
);

  logic [kufea_pkg::SUM_W-1:0]  weight_sum, weight_sum_next;
  logic [kufea_pkg::COST_W-1:0] best_cost, best_cost_next;
  logic [kufea_pkg::EDGE_W-1:0] best_edge, best_edge_next;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    weight_sum_next = weight_sum;
    best_cost_next  = best_cost;
    best_edge_next  = best_edge;
    if (link.merge) begin
      weight_sum_next = weight_sum + kufea_pkg::SUM_W'(link.weight);
      if (link.cost < best_cost) begin
        best_cost_next = link.cost;
        best_edge_next = link.number;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_sum <= '0;
      best_cost  <= kufea_pkg::COST_INIT;
      best_edge  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (link.done) begin
        weight_sum <= weight_sum_next;
        best_cost  <= best_cost_next;
        best_edge  <= best_edge_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (link.done) begin
      out_accepted <= link.merge;
      out_total    <= weight_sum_next;
      out_min_cost <= best_cost_next;
      out_min_edge <= best_edge_next;
    end
  end

  a_cost_never_rises: assert property (@(posedge clk) disable iff (rst)
    !rst |=> (best_cost <= $past(best_cost)))
    else $error("best cost increased");

  a_sum_moves_on_done: assert property (@(posedge clk) disable iff (rst)
    !link.done |=> $stable(weight_sum))
    else $error("weight total changed without a finished edge");

endmodule

`default_nettype wire
